>>> design/srca_pkg.sv
`default_nettype none
// ============================================================================
// srca_pkg: shared definitions for the sensor region coverage accumulator
// Command codes, controller states, default sizes and the per-entry
// contribution flags passed from the table walker to the accumulator.
// ============================================================================
package srca_pkg;

    localparam int NODE_COUNT_DEF   = 32;
    localparam int REGION_DEPTH_DEF = 256;
    localparam int AREA_BITS_DEF    = 24;

    localparam int CMD_BITS      = 2;
    localparam int INDEX_BITS    = 8;
    localparam int AREA_IN_BITS  = 24;
    localparam int MASK_BITS     = 32;
    localparam int CFG_BITS      = 9;
    localparam int SUM_BITS      = 33;
    localparam int SUM_LANES     = 4;

    localparam int LANE_TCOV = 0;
    localparam int LANE_PCOV = 1;
    localparam int LANE_TOVL = 2;
    localparam int LANE_POVL = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NODE_WRITE   = 2'd0,
        CMD_REGION_WRITE = 2'd1,
        CMD_QUERY        = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NODES,
        ST_REGIONS,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic valid;
        logic tcov;
        logic pcov;
        logic tovl;
        logic povl;
    } contrib_t;

endpackage
`default_nettype wire

>>> design/sensor_region_coverage_accumulator_unit.sv
`default_nettype none
// ============================================================================
// sensor_region_coverage_accumulator_unit: coverage query engine
// Keeps per-node exclusive areas and overlap regions in RAM and answers
// coverage queries by walking both tables and summing 16.8 fixed-point areas.
// ============================================================================
// A query walks the node table and then the first region_count entries of
// the region table (capped at REGION_DEPTH), reading one entry per cycle
// from the table RAMs. The input is ready again in the same cycle that the
// result appears. A finished result sits in an output register, so new
// words are taken while it waits; a second query that finishes before the
// first result is taken holds the input off until the output register
// frees up. The region table holds no defined contents until written; the
// node table reads as zero until written.
module sensor_region_coverage_accumulator_unit #(
    parameter int NODE_COUNT   = srca_pkg::NODE_COUNT_DEF,
    parameter int REGION_DEPTH = srca_pkg::REGION_DEPTH_DEF,
    parameter int AREA_BITS    = srca_pkg::AREA_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [srca_pkg::CFG_BITS-1:0]     cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [srca_pkg::CMD_BITS-1:0]     s_command,
    input  wire logic [srca_pkg::INDEX_BITS-1:0]   s_entry_index,
    input  wire logic [srca_pkg::AREA_IN_BITS-1:0] s_area_value,
    input  wire logic [srca_pkg::MASK_BITS-1:0]    s_owner_mask,
    input  wire logic [srca_pkg::MASK_BITS-1:0]    s_ignore_mask,
    input  wire logic [srca_pkg::MASK_BITS-1:0]    s_dead_mask,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [srca_pkg::SUM_BITS-1:0]          m_total_coverage,
    output logic [srca_pkg::SUM_BITS-1:0]          m_partial_coverage,
    output logic [srca_pkg::SUM_BITS-1:0]          m_total_overlap,
    output logic [srca_pkg::SUM_BITS-1:0]          m_partial_overlap
);

    localparam int MB  = srca_pkg::MASK_BITS;
    localparam int SB  = srca_pkg::SUM_BITS;
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int RAW = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
    localparam int RCW = ($clog2(REGION_DEPTH + 1) > srca_pkg::CFG_BITS) ?
                         $clog2(REGION_DEPTH + 1) : srca_pkg::CFG_BITS;
    localparam int RW  = MB + AREA_BITS;

    srca_pkg::state_t state_reg, state_next;

    logic [srca_pkg::CFG_BITS-1:0] region_count_reg;
    logic [RCW-1:0]                count_ext;
    logic [RCW-1:0]                used;

    logic [NW-1:0]   node_cnt_reg, node_cnt_next;
    logic [RCW-1:0]  reg_cnt_reg, reg_cnt_next;
    logic [MB-1:0]   ignore_reg, dead_reg;
    logic [NODE_COUNT-1:0] nvalid_reg;

    logic in_acc, node_we, region_we, query_start;
    logic node_re, region_re, load_out;
    logic [AREA_BITS-1:0] area_in;

    logic [AREA_BITS-1:0] node_rdata;
    logic [RW-1:0]        region_rdata;

    logic            s1_valid_reg, s1_is_node_reg, s1_nvalid_reg;
    logic [NW-1:0]   s1_node_idx_reg;

    logic [MB-1:0]   dead_sh, ign_sh, owners, live, awake;
    srca_pkg::contrib_t contrib_reg, contrib_next;
    logic [AREA_BITS-1:0] area_reg, area_next;

    logic [srca_pkg::SUM_LANES-1:0][SB-1:0] sums;
    logic m_valid_reg;
    logic [SB-1:0] tcov_reg, pcov_reg, tovl_reg, povl_reg;

    // Input decode and configuration.
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == srca_pkg::ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign area_in   = AREA_BITS'(s_area_value);

    always_comb begin
        node_we     = 1'b0;
        region_we   = 1'b0;
        query_start = 1'b0;
        if (in_acc) begin
            case (s_command)
                srca_pkg::CMD_NODE_WRITE: begin
                    node_we = (int'(s_entry_index) < NODE_COUNT);
                end
                srca_pkg::CMD_REGION_WRITE: begin
                    region_we = (int'(s_entry_index) < REGION_DEPTH);
                end
                srca_pkg::CMD_QUERY: begin
                    query_start = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign count_ext = RCW'(region_count_reg);
    assign used      = (count_ext > RCW'(REGION_DEPTH)) ? RCW'(REGION_DEPTH) : count_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_count_reg <= '0;
            nvalid_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                region_count_reg <= cfg_data;
            end
            if (node_we) begin
                nvalid_reg[NW'(s_entry_index)] <= 1'b1;
            end
        end
    end

    // Table memories.
    srca_ram #(
        .WIDTH (AREA_BITS),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (NW'(s_entry_index)),
        .wdata (area_in),
        .re    (node_re),
        .raddr (node_cnt_reg),
        .rdata (node_rdata)
    );

    srca_ram #(
        .WIDTH (RW),
        .DEPTH (REGION_DEPTH)
    ) u_region_ram (
        .aclk  (aclk),
        .we    (region_we),
        .waddr (RAW'(s_entry_index)),
        .wdata ({s_owner_mask, area_in}),
        .re    (region_re),
        .raddr (reg_cnt_reg[RAW-1:0]),
        .rdata (region_rdata)
    );

    // Query sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= srca_pkg::ST_IDLE;
            node_cnt_reg <= '0;
            reg_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            node_cnt_reg <= node_cnt_next;
            reg_cnt_reg  <= reg_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        node_cnt_next = node_cnt_reg;
        reg_cnt_next  = reg_cnt_reg;
        node_re       = 1'b0;
        region_re     = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            srca_pkg::ST_IDLE: begin
                if (query_start) begin
                    state_next    = srca_pkg::ST_NODES;
                    node_cnt_next = '0;
                    reg_cnt_next  = '0;
                end
            end
            srca_pkg::ST_NODES: begin
                node_re       = 1'b1;
                node_cnt_next = node_cnt_reg + 1'b1;
                if (node_cnt_reg == NW'(NODE_COUNT - 1)) begin
                    state_next = (used == '0) ? srca_pkg::ST_FINISH : srca_pkg::ST_REGIONS;
                end
            end
            srca_pkg::ST_REGIONS: begin
                region_re    = 1'b1;
                reg_cnt_next = reg_cnt_reg + 1'b1;
                if (reg_cnt_next == used) begin
                    state_next = srca_pkg::ST_FINISH;
                end
            end
            srca_pkg::ST_FINISH: begin
                if (!s1_valid_reg && !contrib_reg.valid && (!m_valid_reg || m_ready)) begin
                    load_out   = 1'b1;
                    state_next = srca_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (query_start) begin
            ignore_reg <= s_ignore_mask;
            dead_reg   <= s_dead_mask;
        end
    end

    // Read tag, aligned with the registered RAM output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= node_re || region_re;
        end
        s1_is_node_reg  <= node_re;
        s1_nvalid_reg   <= nvalid_reg[node_cnt_reg];
        s1_node_idx_reg <= node_cnt_reg;
    end

    // Contribution of one table entry to each of the four sums.
    always_comb begin
        dead_sh = dead_reg >> s1_node_idx_reg;
        ign_sh  = ignore_reg >> s1_node_idx_reg;
        owners  = region_rdata[AREA_BITS +: MB];
        live    = owners & ~dead_reg;
        awake   = live & ~ignore_reg;

        contrib_next.valid = s1_valid_reg;
        if (s1_is_node_reg) begin
            contrib_next.tcov = !dead_sh[0];
            contrib_next.pcov = !dead_sh[0] && !ign_sh[0];
            contrib_next.tovl = 1'b0;
            contrib_next.povl = 1'b0;
            area_next         = s1_nvalid_reg ? node_rdata : '0;
        end else begin
            contrib_next.tcov = |live;
            contrib_next.pcov = |awake;
            contrib_next.tovl = |(live & (live - 1'b1));
            contrib_next.povl = |(awake & (awake - 1'b1));
            area_next         = region_rdata[AREA_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contrib_reg <= '0;
        end else begin
            contrib_reg <= contrib_next;
        end
        area_reg <= area_next;
    end

    srca_accum #(
        .AREA_BITS (AREA_BITS)
    ) u_accum (
        .aclk    (aclk),
        .clear   (query_start),
        .contrib (contrib_reg),
        .area    (area_reg),
        .sums    (sums)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            tcov_reg <= sums[srca_pkg::LANE_TCOV];
            pcov_reg <= sums[srca_pkg::LANE_PCOV];
            tovl_reg <= sums[srca_pkg::LANE_TOVL];
            povl_reg <= sums[srca_pkg::LANE_POVL];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_total_coverage   = tcov_reg;
    assign m_partial_coverage = pcov_reg;
    assign m_total_overlap    = tovl_reg;
    assign m_partial_overlap  = povl_reg;

    // A new result only ever comes out of the final drain state.
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == srca_pkg::ST_FINISH))
        else $error("result issued outside the finish state");

    // The read pipeline is always empty while waiting for input.
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srca_pkg::ST_IDLE) |-> (!s1_valid_reg && !contrib_reg.valid))
        else $error("table read still in flight while idle");

    // The region walk never reads past the entries in use.
    a_region_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srca_pkg::ST_REGIONS) |-> (reg_cnt_reg < used))
        else $error("region read beyond region count");

endmodule
`default_nettype wire

>>> design/srca_ram.sv
`default_nettype none
// ============================================================================
// srca_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module srca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    aclk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic                    re,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/srca_accum.sv
`default_nettype none
// ============================================================================
// srca_accum: four saturating coverage accumulators
// Adds one area per cycle into each sum whose contribution flag is set.
// ============================================================================
module srca_accum #(
    parameter int AREA_BITS = srca_pkg::AREA_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    clear,
    input  wire srca_pkg::contrib_t                      contrib,
    input  wire logic [AREA_BITS-1:0]                    area,
    output logic [srca_pkg::SUM_LANES-1:0][srca_pkg::SUM_BITS-1:0] sums
);

    localparam int SB = srca_pkg::SUM_BITS;
    localparam logic [SB-1:0] SUM_MAX = '1;

    logic [srca_pkg::SUM_LANES-1:0] lane_en;

    always_comb begin
        lane_en                      = '0;
        lane_en[srca_pkg::LANE_TCOV] = contrib.tcov;
        lane_en[srca_pkg::LANE_PCOV] = contrib.pcov;
        lane_en[srca_pkg::LANE_TOVL] = contrib.tovl;
        lane_en[srca_pkg::LANE_POVL] = contrib.povl;
    end

    for (genvar k = 0; k < srca_pkg::SUM_LANES; k++) begin : g_lane
        logic [SB-1:0] acc_reg;
        logic [SB-1:0] acc_next;
        logic [SB:0]   sum;

        always_comb begin
            sum      = {1'b0, acc_reg} + (SB + 1)'(area);
            acc_next = sum[SB] ? SUM_MAX : sum[SB-1:0];
        end

        always_ff @(posedge aclk) begin
            if (clear) begin
                acc_reg <= '0;
            end else if (contrib.valid && lane_en[k]) begin
                acc_reg <= acc_next;
            end
        end

        assign sums[k] = acc_reg;
    end

endmodule
`default_nettype wire
